[src/deq_pkg.sv]
// Shared types and codes for the double-ended queue core.
// Used by the core and its port checker; depends on nothing.
package deq_pkg;

   localparam int DATA_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND     = 3'd0,
      KIND_DROP_FRONT = 3'd1,
      KIND_DROP_BACK  = 3'd2,
      KIND_DUMP_FWD   = 3'd3,
      KIND_DUMP_BACK  = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ELEM  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

[src/double_ended_queue_core.sv]
// Bounded deque of signed 32-bit words in a ring buffer: append back, drop front/back, dumps.
// Depends on deq_pkg and deq_ram.
//
// A request is taken when start is high and busy is low. Append and drop requests never
// raise busy; a rejected append (deque full) shows its status result in the cycle after
// the request. A dump of N stored words holds busy high while it walks them and emits one
// word per cycle. The first word is on the ports once the state register has entered the
// dump state and the RAM read register has captured it, later than a status result would
// be. The last word is on the ports in the first cycle with busy low and is marked by
// rsp_last. The pace is set by the single read port of the element RAM and the one
// ring-address adder that walks it. A dump of an empty deque gives one empty-status
// result in the cycle after the request. Results appear for exactly one cycle on rsp_valid
// and must be taken then; there is no way to hold them off.
module double_ended_queue_core #(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_kind,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_data,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     off_ff, off_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic                  back_ff, back_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_elem_ff, rsp_elem_in;
   deq_pkg::status_type   rsp_status_ff, rsp_status_in;

   logic                  full, empty, accept;
   logic [ADDR_W-1:0]     unit_off;
   logic [ADDR_W:0]       ring_sum;
   logic [ADDR_W-1:0]     ring_pos;
   logic                  wr_en, rd_en;
   logic [31:0]           rd_data;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign accept = start && (state_ff == S_IDLE);

   // shared ring-address unit: (front + offset) mod DEPTH
   always_comb begin
      priority if (state_ff == S_DUMP) begin
         unit_off = off_ff;
      end else if (req_kind == deq_pkg::KIND_APPEND) begin
         unit_off = count_ff[ADDR_W-1:0];
      end else begin
         unit_off = ADDR_W'(1);
      end
   end

   assign ring_sum = {1'b0, front_ff} + {1'b0, unit_off};
   assign ring_pos = (ring_sum >= (ADDR_W+1)'(DEPTH))
                     ? ADDR_W'(ring_sum - (ADDR_W+1)'(DEPTH))
                     : ring_sum[ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      off_in        = off_ff;
      rem_in        = rem_ff;
      back_in       = back_ff;
      rsp_valid_in  = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_elem_in   = 1'b0;
      rsp_status_in = deq_pkg::STATUS_ELEM;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  deq_pkg::KIND_APPEND: begin
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = deq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  deq_pkg::KIND_DROP_FRONT: begin
                     if (!empty) begin
                        front_in = ring_pos;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  deq_pkg::KIND_DROP_BACK: begin
                     if (!empty) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  deq_pkg::KIND_DUMP_FWD, deq_pkg::KIND_DUMP_BACK: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = deq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = S_DUMP;
                        back_in  = (req_kind == deq_pkg::KIND_DUMP_BACK);
                        off_in   = (req_kind == deq_pkg::KIND_DUMP_BACK)
                                   ? ADDR_W'(count_ff - CNT_W'(1)) : '0;
                        rem_in   = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DUMP: begin
            // read issued now, word comes out of the RAM register with the result beat
            rd_en        = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_elem_in  = 1'b1;
            rsp_last_in  = (rem_ff == CNT_W'(1));
            off_in       = back_ff ? off_ff - ADDR_W'(1) : off_ff + ADDR_W'(1);
            rem_in       = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         rsp_elem_ff   <= 1'b0;
         rsp_status_ff <= deq_pkg::STATUS_ELEM;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_elem_ff   <= rsp_elem_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff  <= off_in;
      rem_ff  <= rem_in;
      back_ff <= back_in;
   end

   deq_ram #(
      .WIDTH (deq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ring_pos),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (ring_pos),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff == S_DUMP);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_elem_ff ? $signed(rd_data) : '0;

endmodule

[src/deq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/deq_checker.sv]
// Port-level checks for double_ended_queue_core, bound onto the top level.
// Depends on deq_pkg.
module deq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [2:0]         req_kind,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_data,
   input logic [1:0]         rsp_status,
   input logic               rsp_last
);

   // dump words come out back to back, none marked last while the walk continues
   a_dump_stream: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(busy) && busy) |-> (rsp_valid && !rsp_last))
      else $error("dump beat missing or marked last mid-walk");

   // the final dump word is on the ports when busy drops
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> (rsp_valid && rsp_last))
      else $error("dump ended without a last beat");

   // no beat in the first busy cycle: the first word is still in the RAM read
   a_dump_start: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(busy)) |-> !rsp_valid)
      else $error("unexpected beat at dump start");

   // status results are single beats with zero data
   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != deq_pkg::STATUS_ELEM)) |-> (rsp_last && (rsp_data == '0)))
      else $error("status beat not last or carries data");

   // a full status answers an append taken on the edge before
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == deq_pkg::STATUS_FULL))
      |-> $past(start && !busy && (req_kind == deq_pkg::KIND_APPEND)))
      else $error("full status without a preceding append");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (.*);
